>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the overlap checker.
// No dependencies; take it by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, muted in reset.
`define BFOC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, muted in reset.
`define BFOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bfoc_pkg.sv
// Shared types and constants of the bit-field overlap checker.
// No dependencies; imported by every module of the block but bfoc_ram.
package bfoc_pkg;

	localparam int WORD_W  = 16;
	localparam int MASK_W  = 32;
	localparam int NUM_TYPES = 4;
	localparam int CFG_IDX_W = 8;

	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [MASK_W-1:0]     mask_t;
	typedef mask_t [NUM_TYPES-1:0] mask_set_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	localparam mask_t FULL_MASK = '1;

	// Configuration register indexes
	localparam cfg_idx_t REG_TYPE_MASK_ZERO  = 8'd0;
	localparam cfg_idx_t REG_TYPE_MASK_ONE   = 8'd1;
	localparam cfg_idx_t REG_TYPE_MASK_TWO   = 8'd2;
	localparam cfg_idx_t REG_TYPE_MASK_THREE = 8'd3;

	// Reset values of the type masks
	localparam mask_t RST_MASK_ZERO  = 32'h0000_0001;
	localparam mask_t RST_MASK_ONE   = 32'h0000_00FF;
	localparam mask_t RST_MASK_TWO   = 32'h0000_FFFF;
	localparam mask_t RST_MASK_THREE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic       set_start;
		logic [7:0] word_offset;
		logic [3:0] bit_offset;
		logic [1:0] field_type;
	} item_t;

	typedef struct packed {
		logic item_checked;
		logic item_free;
		logic set_clean;
	} result_t;

	// Write request from the check stage to one map bank
	typedef struct packed {
		logic  clr;
		logic  en;
		word_t data;
	} bank_wr_t;

endpackage

>>> sv/bfoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfoc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/bfoc_cfg.sv
// Type mask register file of the overlap checker.
// Depends on bfoc_pkg.
module bfoc_cfg
	import bfoc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_idx_t  cfg_index,
	input  mask_t     cfg_data,
	output mask_set_t masks
);

	mask_set_t masks_q;

	assign cfg_ready = 1'b1;
	assign masks     = masks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q[0] <= RST_MASK_ZERO;
			masks_q[1] <= RST_MASK_ONE;
			masks_q[2] <= RST_MASK_TWO;
			masks_q[3] <= RST_MASK_THREE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TYPE_MASK_ZERO:  masks_q[0] <= cfg_data;
				REG_TYPE_MASK_ONE:   masks_q[1] <= cfg_data;
				REG_TYPE_MASK_TWO:   masks_q[2] <= cfg_data;
				REG_TYPE_MASK_THREE: masks_q[3] <= cfg_data;
				// drop writes past the register list
				default: ;
			endcase
		end
	end

endmodule

>>> sv/bfoc_bank.sv
// One bank of the occupancy map: RAM, per-word valid bits and a write forward.
// Depends on bfoc_pkg and bfoc_ram.
module bfoc_bank
	import bfoc_pkg::*;
#(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  bank_wr_t      wr,
	output word_t         word
);

	logic [AW-1:0]    addr_s1;
	logic [DEPTH-1:0] valid_q;
	logic             fwd_en_q;
	logic [AW-1:0]    fwd_addr_q;
	word_t            fwd_data_q;
	word_t            rdata;
	logic             fwd_hit;

	bfoc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (addr_s1),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			fwd_en_q <= 1'b0;
		end else begin
			fwd_en_q <= wr.en;
			if (wr.clr) begin
				valid_q <= '0;
			end
			if (wr.en) begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// The RAM returns stale data when the previous beat wrote the same word
	assign fwd_hit = fwd_en_q && (fwd_addr_q == addr_s1);

	always_comb begin
		if (!valid_q[addr_s1]) begin
			word = '0;
		end else if (fwd_hit) begin
			word = fwd_data_q;
		end else begin
			word = rdata;
		end
	end

endmodule

>>> sv/bit_field_overlap_checker_core.sv
// Bit-field overlap checker: keeps an occupancy bitmap of 16-bit words and
// reports whether each field of a clean set lands on free bits, then marks those bits.
//
// Item channel: an item beat is taken at a rising edge with start high and
// busy low. busy stays low: one item is taken every cycle.
// Result channel: done is high for one cycle with result; an accepted item
// is registered into the check stage (item_s1, act_s1 and the map RAM read),
// then into done_q and result_q. The receiver cannot stall.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no item is in flight.
// The map is split into even and odd word banks so that a 32-bit field
// reads and writes both of its words in one pass; a write forward covers
// back-to-back items on the same word.
// Reset: type masks take their defaults, all map words read as zero and the
// set is clean. An item with set_start clears the map before it is checked.
// Depends on bfoc_pkg, bfoc_cfg and bfoc_bank.
module bit_field_overlap_checker_core
	import bfoc_pkg::*;
#(
	parameter int MAP_WORDS = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  item_t    item,
	output logic     done,
	output result_t  result,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  mask_t    cfg_data
);

	// Only words 0 to 256 can ever be addressed
	localparam int SPAN     = (MAP_WORDS < 257) ? MAP_WORDS : 257;
	localparam int EV_DEPTH = (SPAN + 1) / 2;
	localparam int OD_DEPTH = SPAN / 2;
	localparam int EV_AW    = (EV_DEPTH > 1) ? $clog2(EV_DEPTH) : 1;
	localparam int OD_AW    = (OD_DEPTH > 1) ? $clog2(OD_DEPTH) : 1;
	localparam logic [16:0] MAP_LIM = 17'(MAP_WORDS);

	mask_set_t        masks;
	logic             accept;
	logic [8:0]       ev_sum;
	logic [7:0]       ev_half;
	logic [7:0]       od_half;
	logic             act_s1;
	item_t            item_s1;
	word_t            ev_word;
	word_t            od_word;
	bank_wr_t         ev_wr;
	bank_wr_t         od_wr;
	logic             clean_q;
	logic             done_q;
	result_t          result_q;

	mask_t            mask;
	logic             full;
	mask_t            bits32;
	word_t            lo_bits;
	word_t            hi_bits;
	logic [8:0]       lo_idx;
	logic [8:0]       hi_idx;
	logic             lo_in;
	logic             hi_in;
	word_t            cur_lo;
	word_t            cur_hi;
	logic             checked;
	logic             free_ok;
	logic             lo_en;
	logic             hi_en;
	word_t            lo_data;
	word_t            hi_data;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	bfoc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.masks     (masks)
	);

	// Word w and w+1 always fall in different banks
	assign ev_sum  = {1'b0, item.word_offset} + 9'd1;
	assign ev_half = ev_sum[8:1];
	assign od_half = {1'b0, item.word_offset[7:1]};

	bfoc_bank #(
		.DEPTH (EV_DEPTH),
		.AW    (EV_AW)
	) u_bank_ev (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (ev_half[EV_AW-1:0]),
		.wr      (ev_wr),
		.word    (ev_word)
	);

	bfoc_bank #(
		.DEPTH (OD_DEPTH),
		.AW    (OD_AW)
	) u_bank_od (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (od_half[OD_AW-1:0]),
		.wr      (od_wr),
		.word    (od_word)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		result_q.item_checked <= checked;
		result_q.item_free    <= checked && free_ok;
		result_q.set_clean    <= checked && free_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= 1'b0;
			done_q  <= 1'b0;
			clean_q <= 1'b1;
		end else begin
			act_s1 <= accept;
			done_q <= act_s1;
			if (act_s1) begin
				clean_q <= checked && free_ok;
			end
		end
	end

	// Check stage: shape the field and test it against both words
	always_comb begin
		mask   = masks[item_s1.field_type];
		full   = (mask == FULL_MASK);
		bits32 = mask << item_s1.bit_offset;
		if (full) begin
			lo_bits = bits32[15:0];
			hi_bits = bits32[31:16];
		end else begin
			lo_bits = mask[15:0] << item_s1.bit_offset;
			hi_bits = '0;
		end

		lo_idx = {1'b0, item_s1.word_offset};
		hi_idx = lo_idx + 9'd1;
		lo_in  = {8'd0, lo_idx} < MAP_LIM;
		hi_in  = {8'd0, hi_idx} < MAP_LIM;

		if (item_s1.set_start || !lo_in) begin
			cur_lo = '0;
		end else begin
			cur_lo = item_s1.word_offset[0] ? od_word : ev_word;
		end
		if (item_s1.set_start || !hi_in) begin
			cur_hi = '0;
		end else begin
			cur_hi = item_s1.word_offset[0] ? ev_word : od_word;
		end

		checked = item_s1.set_start || clean_q;
		free_ok = ((cur_lo & lo_bits) == '0) && ((cur_hi & hi_bits) == '0);

		lo_en   = act_s1 && checked && lo_in;
		hi_en   = act_s1 && checked && full && hi_in;
		lo_data = cur_lo | lo_bits;
		hi_data = cur_hi | hi_bits;
	end

	always_comb begin
		ev_wr.clr = act_s1 && item_s1.set_start;
		od_wr.clr = act_s1 && item_s1.set_start;
		if (item_s1.word_offset[0]) begin
			od_wr.en   = lo_en;
			od_wr.data = lo_data;
			ev_wr.en   = hi_en;
			ev_wr.data = hi_data;
		end else begin
			ev_wr.en   = lo_en;
			ev_wr.data = lo_data;
			od_wr.en   = hi_en;
			od_wr.data = hi_data;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> sv/bfoc_chk.sv
// Port-level checks of the overlap checker, bound to the top level.
// Depends on bfoc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bfoc_chk
	import bfoc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input item_t    item,
	input logic     done,
	input result_t  result
);

	`BFOC_ASSERT_NEXT(a_item_gives_result, clk, arst_n, start && !busy, ##1 done,
		"accepted item gave no result two cycles later")

	`BFOC_ASSERT_SAME(a_result_has_item, clk, arst_n, done, $past(start && !busy, 2),
		"result without an accepted item")

	`BFOC_ASSERT_SAME(a_skip_reports_nothing, clk, arst_n, done && !result.item_checked,
		!result.item_free && !result.set_clean, "skipped item reports free or clean")

	`BFOC_ASSERT_SAME(a_clean_tracks_free, clk, arst_n, done && result.item_checked,
		result.set_clean == result.item_free, "set_clean disagrees with item_free")

	`BFOC_ASSERT_SAME(a_set_start_checked, clk, arst_n,
		done && $past(item.set_start, 2), result.item_checked,
		"item opening a set was skipped")

endmodule

bind bit_field_overlap_checker_core bfoc_chk u_bfoc_chk (.*);

>>> test/tb.sv
// Testbench for bit_field_overlap_checker_core: random and directed field placements
// are checked against an in-bench occupancy map predictor, beat by beat.
// Depends on bfoc_pkg and the core RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfoc_pkg::*;

	localparam int MAP_WORDS    = 256;
	localparam int QUIET_CYCLES = 4;
	localparam int RAND_PHASES  = 7;
	localparam int PHASE_ITEMS  = 250;

	localparam cfg_idx_t REG_PAST_END = REG_TYPE_MASK_THREE + 8'd1;
	localparam cfg_idx_t REG_TOP      = '1;

	localparam logic [1:0] TYPE_ZERO  = 2'd0;
	localparam logic [1:0] TYPE_ONE   = 2'd1;
	localparam logic [1:0] TYPE_TWO   = 2'd2;
	localparam logic [1:0] TYPE_THREE = 2'd3;

	typedef enum logic [1:0] {OP_ITEM, OP_REG_WRITE, OP_QUIESCE} op_kind_e;

	typedef struct {
		op_kind_e kind;
		item_t    fld;
		cfg_idx_t idx;
		mask_t    data;
		int       gap;
	} op_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     start     = 1'b0;
	item_t    item      = '0;
	logic     cfg_valid = 1'b0;
	cfg_idx_t cfg_index = REG_TYPE_MASK_ZERO;
	mask_t    cfg_data  = '0;
	logic     busy;
	logic     done;
	logic     cfg_ready;
	result_t  result;

	bit_field_overlap_checker_core #(
		.MAP_WORDS(MAP_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	op_t     work_q[$];
	result_t verdict_q[$];
	int      err_count = 0;

	// Predictor state: masks, map words, which words hold data, clean flag
	mask_set_t            type_mask;
	word_t                occ_map [MAP_WORDS];
	logic [MAP_WORDS-1:0] word_seen;
	logic                 map_clean;

	// Driver temporaries
	logic     nxt_start;
	logic     nxt_cfg_valid;
	item_t    nxt_item;
	cfg_idx_t nxt_idx;
	mask_t    nxt_data;
	int       quiet_cnt = 0;
	int       gap_cnt = 0;
	result_t  want;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		err_count++;
	endtask

	// While the set is clean, test the field against the map, then mark its bits
	function automatic result_t mark_field(item_t f);
		int      w;
		mask_t   m;
		mask_t   bits;
		word_t   lo_bits;
		word_t   hi_bits;
		word_t   lo;
		word_t   hi;
		logic    wide;
		logic    ok;
		result_t r;
		w = f.word_offset;
		if (f.set_start) begin
			word_seen = '0;
			map_clean = 1'b1;
		end
		if (!map_clean)
			return '0;
		m = type_mask[f.field_type];
		wide = (m == FULL_MASK);
		if (wide) begin
			bits = m << f.bit_offset;
			lo_bits = bits[15:0];
			hi_bits = bits[31:16];
		end else begin
			lo_bits = m[15:0] << f.bit_offset;
			hi_bits = '0;
		end
		lo = (w < MAP_WORDS && word_seen[w]) ? occ_map[w] : '0;
		hi = (wide && w + 1 < MAP_WORDS && word_seen[w + 1]) ? occ_map[w + 1] : '0;
		ok = ((lo & lo_bits) == '0) && ((hi & hi_bits) == '0);
		// drop writes past the map end
		if (w < MAP_WORDS) begin
			occ_map[w] = lo | lo_bits;
			word_seen[w] = 1'b1;
		end
		if (wide && w + 1 < MAP_WORDS) begin
			occ_map[w + 1] = hi | hi_bits;
			word_seen[w + 1] = 1'b1;
		end
		if (!ok)
			map_clean = 1'b0;
		r.item_checked = 1'b1;
		r.item_free = ok;
		r.set_clean = map_clean;
		return r;
	endfunction

	task automatic queue_item(logic ss, logic [7:0] w, logic [3:0] b, logic [1:0] t, int gap);
		op_t op;
		op.kind = OP_ITEM;
		op.fld.set_start = ss;
		op.fld.word_offset = w;
		op.fld.bit_offset = b;
		op.fld.field_type = t;
		op.idx = '0;
		op.data = '0;
		op.gap = gap;
		work_q.push_back(op);
	endtask

	task automatic queue_reg(cfg_idx_t idx, mask_t data);
		op_t op;
		op.kind = OP_REG_WRITE;
		op.fld = '0;
		op.idx = idx;
		op.data = data;
		op.gap = 0;
		work_q.push_back(op);
	endtask

	task automatic queue_quiesce();
		op_t op;
		op.kind = OP_QUIESCE;
		op.fld = '0;
		op.idx = '0;
		op.data = '0;
		op.gap = 0;
		work_q.push_back(op);
	endtask

	// Driver: take accepted beats into the predictor, then launch the next one
	always @(posedge clk) begin
		if (arst_n) begin
			nxt_start = start;
			nxt_cfg_valid = cfg_valid;
			nxt_item = item;
			nxt_idx = cfg_index;
			nxt_data = cfg_data;
			if (start && !busy) begin
				verdict_q.push_back(mark_field(item));
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index <= REG_TYPE_MASK_THREE)
					type_mask[cfg_index[1:0]] = cfg_data;
				nxt_cfg_valid = 1'b0;
			end
			if (verdict_q.size() == 0 && !start)
				quiet_cnt++;
			else
				quiet_cnt = 0;
			if (!nxt_start && !nxt_cfg_valid && work_q.size() != 0) begin
				case (work_q[0].kind)
				OP_ITEM: begin
					if (gap_cnt < work_q[0].gap) begin
						gap_cnt++;
					end else begin
						nxt_start = 1'b1;
						nxt_item = work_q[0].fld;
						gap_cnt = 0;
						void'(work_q.pop_front());
					end
				end
				OP_REG_WRITE: begin
					if (verdict_q.size() == 0 && quiet_cnt >= QUIET_CYCLES) begin
						nxt_cfg_valid = 1'b1;
						nxt_idx = work_q[0].idx;
						nxt_data = work_q[0].data;
						void'(work_q.pop_front());
					end
				end
				default: begin
					if (verdict_q.size() == 0 && quiet_cnt >= QUIET_CYCLES)
						void'(work_q.pop_front());
				end
				endcase
			end
			start <= nxt_start;
			item <= nxt_item;
			cfg_valid <= nxt_cfg_valid;
			cfg_index <= nxt_idx;
			cfg_data <= nxt_data;
		end
	end

	// Monitor: every result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (verdict_q.size() == 0) begin
				flag_mismatch("result beat with nothing expected");
			end else begin
				want = verdict_q.pop_front();
				if (result.item_checked !== want.item_checked)
					flag_mismatch($sformatf("item_checked got %b expected %b",
						result.item_checked, want.item_checked));
				if (result.item_free !== want.item_free)
					flag_mismatch($sformatf("item_free got %b expected %b",
						result.item_free, want.item_free));
				if (result.set_clean !== want.set_clean)
					flag_mismatch($sformatf("set_clean got %b expected %b",
						result.set_clean, want.set_clean));
			end
		end
	end

	initial begin
		int    ph;
		int    r;
		int    n;
		int    k;
		int    set_len;
		int    base;
		int    w;
		int    gap;
		int    sel;
		logic  ss;
		logic  idle_set;
		logic  paused;
		mask_t m;

		type_mask = {RST_MASK_THREE, RST_MASK_TWO, RST_MASK_ONE, RST_MASK_ZERO};
		word_seen = '0;
		map_clean = 1'b1;
		paused = 1'b0;

		// Reset masks; items before any set start see the empty map
		queue_item(1'b0, 8'd0, 4'd0, TYPE_ZERO, 0);
		queue_item(1'b0, 8'd0, 4'd0, TYPE_ZERO, 1);
		queue_item(1'b0, 8'd255, 4'd15, TYPE_THREE, 0);
		queue_item(1'b1, 8'd0, 4'd0, TYPE_TWO, 0);
		queue_item(1'b0, 8'd0, 4'd15, TYPE_ZERO, 2);
		queue_item(1'b0, 8'd1, 4'd0, TYPE_ONE, 0);
		// wide field at the map end, then its neighbours
		queue_item(1'b1, 8'd255, 4'd15, TYPE_THREE, 0);
		queue_item(1'b0, 8'd255, 4'd0, TYPE_ONE, 0);
		queue_item(1'b0, 8'd254, 4'd0, TYPE_THREE, 3);
		queue_item(1'b1, 8'd254, 4'd1, TYPE_THREE, 0);
		queue_item(1'b0, 8'd128, 4'd15, TYPE_ONE, 0);

		queue_reg(REG_TYPE_MASK_ZERO, 32'h0000_0000);
		queue_reg(REG_TYPE_MASK_ONE, 32'hFFFF_0000);
		queue_reg(REG_TYPE_MASK_TWO, 32'h8000_0001);
		queue_reg(REG_TYPE_MASK_THREE, 32'hFFFF_FFFE);
		queue_reg(REG_PAST_END, 32'h0000_0000);
		queue_reg(REG_TOP, 32'h0000_1234);
		queue_item(1'b1, 8'd7, 4'd0, TYPE_ZERO, 0);
		queue_item(1'b0, 8'd7, 4'd0, TYPE_ZERO, 0);
		queue_item(1'b0, 8'd7, 4'd15, TYPE_ONE, 1);
		queue_item(1'b0, 8'd7, 4'd15, TYPE_TWO, 0);
		queue_item(1'b0, 8'd7, 4'd15, TYPE_TWO, 0);
		queue_item(1'b0, 8'd7, 4'd0, TYPE_THREE, 0);
		queue_item(1'b1, 8'd7, 4'd0, TYPE_THREE, 0);

		queue_reg(REG_TYPE_MASK_ZERO, FULL_MASK);
		queue_reg(REG_TYPE_MASK_THREE, FULL_MASK);
		queue_item(1'b1, 8'd255, 4'd0, TYPE_ZERO, 0);
		queue_item(1'b0, 8'd0, 4'd0, TYPE_ZERO, 0);
		queue_item(1'b0, 8'd1, 4'd15, TYPE_ZERO, 2);
		queue_item(1'b0, 8'd2, 4'd0, TYPE_ONE, 0);
		queue_quiesce();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			for (r = 0; r < NUM_TYPES; r++) begin
				sel = $urandom_range(0, 5);
				case (sel)
				0: m = '0;
				1: m = FULL_MASK;
				2: m = 32'h1 << $urandom_range(0, 15);
				3: m = (32'h1 << $urandom_range(1, 8)) - 32'h1;
				4: m = $urandom;
				default: m = $urandom_range(0, 16'hFFFF);
				endcase
				queue_reg(REG_TYPE_MASK_ZERO + cfg_idx_t'(r), m);
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				set_len = $urandom_range(1, 12);
				base = $urandom_range(0, 255);
				// no idling in the last phase
				idle_set = (ph != RAND_PHASES - 1) && ($urandom_range(0, 2) != 0);
				for (k = 0; k < set_len; k++) begin
					if (k == 0)
						ss = ($urandom_range(0, 19) != 0);
					else
						ss = ($urandom_range(0, 29) == 0);
					w = ($urandom_range(0, 9) != 0) ? base + $urandom_range(0, 3)
						: $urandom_range(0, 255);
					gap = (idle_set && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
					queue_item(ss, 8'(w), 4'($urandom_range(0, 15)),
						2'($urandom_range(0, 3)), gap);
					n++;
				end
				// hold the sender until every result is back
				if (ph == 2 && n >= PHASE_ITEMS / 2 && !paused) begin
					queue_quiesce();
					paused = 1'b1;
				end
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (work_q.size() != 0 || start || verdict_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES + 4) @(posedge clk);
		if (verdict_q.size() != 0)
			flag_mismatch("expected results left over");
		if (err_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb failed");
		$finish;
	end

endmodule
